// File: hw/rtl/mmrc_pkg.sv
// ----------------------------------------------------------------------------
// mmrc_pkg
// Shared types and constants for the mesh map reference checker: report
// kinds, register indexes, field widths and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package mmrc_pkg;

  // Fixed field widths of the item and result ports.
  localparam int ENTRY_W = 32;
  localparam int INDEX_W = 16;
  localparam int ERR_W   = 32;
  localparam int TALLY_W = 17;
  localparam int TSIZE_W = 17;
  localparam int RWID_W  = 4;
  localparam int CFG_W   = 17;
  localparam int CFGI_W  = 2;

  // Reference counts saturate at this value.
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  // Register indexes on the configuration port.
  localparam logic [CFGI_W-1:0] CFG_IDENTITY  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_TARGET_SZ = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_ROW_WIDTH = 2'd2;

  // Reset values of the registers.
  localparam logic                IDENTITY_RST  = 1'b1;
  localparam logic [TSIZE_W-1:0]  TARGET_SZ_RST = 17'd65536;
  localparam logic [RWID_W-1:0]   ROW_WIDTH_RST = 4'd3;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_RANGE   = 2'd0,
    KIND_ROW     = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // register the incoming entry, start its count read
    logic upd;         // update the count and row state, load a result
    logic load_row;    // load the pending row report into the output
    logic scan_step;   // read the next count of the finish scan
    logic clear_step;  // zero the next count after reset
    logic load_sum;    // load the summary and clear all counters
  } mmrc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;  // the entry in update produces at least one result
    logic row_pend;    // a row report waits behind the current result
    logic sweep_last;  // the sweep address is at the last table entry
  } mmrc_sts_t;

endpackage : mmrc_pkg

`default_nettype wire

// File: hw/rtl/mmrc_ctrl.sv
// ----------------------------------------------------------------------------
// mmrc_ctrl
// Controller of the checker: sequences the reset clearing pass, entry
// updates, the finish scan and the hand-off of result items.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrc_ctrl
  import mmrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_cmd,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire mmrc_sts_t sts,
  output mmrc_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_SCAN,
    S_FLUSH,
    S_SUM,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;
  logic   out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_cmd ? S_SCAN : S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.has_result ? S_OUT : S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // The last count read is being tallied.
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.load_sum = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (sts.row_pend) begin
            cmd.load_row = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= (state_nxt != S_IDLE);
      out_valid_r <= (state_nxt == S_OUT);
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule : mmrc_ctrl

`default_nettype wire

// File: hw/rtl/mmrc_dp.sv
// ----------------------------------------------------------------------------
// mmrc_dp
// Datapath of the checker: configuration registers, the reference count
// memory, row and error counters, the scan tallies and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrc_dp
  import mmrc_pkg::*;
#(
  parameter int MAX_SET_SIZE  = 65536,
  parameter int MAX_ROW_WIDTH = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mmrc_cmd_t           cmd,
  output mmrc_sts_t                sts,
  input  wire logic [ENTRY_W-1:0]  in_entry_value,
  input  wire logic                cfg_we,
  input  wire logic [CFGI_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  output logic [1:0]               out_report_kind,
  output logic [INDEX_W-1:0]       out_report_index,
  output logic [ERR_W-1:0]         out_error_total,
  output logic [TALLY_W-1:0]       out_unreferenced_count,
  output logic [TALLY_W-1:0]       out_overreferenced_count,
  output logic                     out_passed,
  output logic                     out_last
);

  localparam int ADDR_W = $clog2(MAX_SET_SIZE);
  localparam int SZW    = $clog2(MAX_SET_SIZE + 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_SET_SIZE - 1);

  // Configuration registers.
  logic               identity_r;
  logic [TSIZE_W-1:0] tsize_r;
  logic [RWID_W-1:0]  rwid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      identity_r <= IDENTITY_RST;
      tsize_r    <= TARGET_SZ_RST;
      rwid_r     <= ROW_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDENTITY:  identity_r <= cfg_wdata[0];
        CFG_TARGET_SZ: tsize_r    <= cfg_wdata[TSIZE_W-1:0];
        CFG_ROW_WIDTH: rwid_r     <= cfg_wdata[RWID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective set size and row width after clamping.
  logic [SZW-1:0]    eff_size;
  logic [RWID_W-1:0] eff_w;

  always_comb begin
    if (32'(tsize_r) > 32'(MAX_SET_SIZE)) begin
      eff_size = SZW'(MAX_SET_SIZE);
    end else begin
      eff_size = SZW'(tsize_r);
    end
    if (rwid_r == '0) begin
      eff_w = RWID_W'(1);
    end else if (int'(rwid_r) > MAX_ROW_WIDTH) begin
      eff_w = RWID_W'(MAX_ROW_WIDTH);
    end else begin
      eff_w = rwid_r;
    end
  end

  // Reference count memory with a registered read port.
  logic [CNT_W-1:0]  cnt_mem_r [MAX_SET_SIZE];
  logic [CNT_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0]  wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= cnt_mem_r[rd_addr];
  end

  // Entry, row and error state.
  logic [ENTRY_W-1:0] entry_r;
  logic [INDEX_W-1:0] row_r;
  logic [RWID_W-1:0]  col_r;
  logic               rowref_r;
  logic [ERR_W-1:0]   err_r;
  logic               rowpend_r;
  logic [INDEX_W-1:0] pend_idx_r;

  // Sweep address shared by the clearing pass and the finish scan.
  logic [ADDR_W-1:0] sweep_r;
  logic [ADDR_W-1:0] sweep_nxt;
  logic              sweep_last;
  logic              pv_r;
  logic [ADDR_W-1:0] pa_r;

  // Scan tallies.
  logic [SZW-1:0]    unref_r;
  logic [SZW-1:0]    over_r;
  logic              found_r;
  logic [ADDR_W-1:0] first_r;

  // Output register.
  kind_t              o_kind_r;
  logic [INDEX_W-1:0] o_idx_r;
  logic [ERR_W-1:0]   o_err_r;
  logic [TALLY_W-1:0] o_unref_r;
  logic [TALLY_W-1:0] o_over_r;
  logic               o_pass_r;
  logic               o_last_r;

  assign sweep_last = (sweep_r == ADDR_LAST);
  assign sweep_nxt  = sweep_last ? '0 : sweep_r + 1'b1;

  // Saturating error increment, used at most once per cycle.
  logic [ERR_W-1:0] err_inc;
  assign err_inc = (err_r == '1) ? err_r : err_r + 1'b1;

  // Entry evaluation during the update cycle.
  logic              oor;
  logic              in_range;
  logic              rowref_new;
  logic [RWID_W-1:0] col_inc;
  logic              close;
  logic              rowrep;
  logic [CNT_W-1:0]  cnt_inc;

  always_comb begin
    oor        = entry_r[ENTRY_W-1] || (entry_r >= ENTRY_W'(eff_size));
    in_range   = !oor;
    rowref_new = rowref_r || (in_range && (entry_r != ENTRY_W'(row_r)) && (entry_r != '0));
    col_inc    = col_r + 1'b1;
    close      = (col_inc >= eff_w);
    rowrep     = close && identity_r && !rowref_new;
    cnt_inc    = (rd_data_r == CNT_MAX) ? rd_data_r : rd_data_r + 1'b1;
  end

  // Scan evaluation of the count read in the previous cycle.
  logic scan_in_set;
  logic scan_zero;
  logic scan_over;
  logic scan_bad;

  always_comb begin
    scan_in_set = pv_r && (32'(pa_r) < 32'(eff_size));
    scan_zero   = scan_in_set && (rd_data_r == '0);
    scan_over   = scan_in_set && identity_r && (rd_data_r > eff_w);
    scan_bad    = scan_zero || scan_over;
  end

  // Memory port selection.
  always_comb begin
    rd_addr = cmd.scan_step ? sweep_r : in_entry_value[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = entry_r[ADDR_W-1:0];
    wr_data = cnt_inc;
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
      wr_data = '0;
    end else if (pv_r) begin
      wr_en   = 1'b1;
      wr_addr = pa_r;
      wr_data = '0;
    end else if (cmd.upd && in_range) begin
      wr_en = 1'b1;
    end
  end

  // Control counters and tallies.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      rowref_r  <= 1'b0;
      err_r     <= '0;
      rowpend_r <= 1'b0;
      sweep_r   <= '0;
      pv_r      <= 1'b0;
      unref_r   <= '0;
      over_r    <= '0;
      found_r   <= 1'b0;
    end else begin
      pv_r <= cmd.scan_step;
      if (cmd.clear_step || cmd.scan_step) begin
        sweep_r <= sweep_nxt;
      end
      if (cmd.upd) begin
        if (oor || rowrep) begin
          err_r <= err_inc;
        end
        rowpend_r <= oor && rowrep;
        if (close) begin
          col_r    <= '0;
          rowref_r <= 1'b0;
          row_r    <= row_r + 1'b1;
        end else begin
          col_r    <= col_inc;
          rowref_r <= rowref_new;
        end
      end
      if (cmd.load_row) begin
        err_r     <= err_inc;
        rowpend_r <= 1'b0;
      end
      if (scan_bad) begin
        err_r <= err_inc;
        if (!found_r) begin
          found_r <= 1'b1;
        end
      end
      if (scan_zero) begin
        unref_r <= unref_r + 1'b1;
      end
      if (scan_over) begin
        over_r <= over_r + 1'b1;
      end
      if (cmd.load_sum) begin
        row_r    <= '0;
        col_r    <= '0;
        rowref_r <= 1'b0;
        err_r    <= '0;
        unref_r  <= '0;
        over_r   <= '0;
        found_r  <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      entry_r <= in_entry_value;
    end
    if (cmd.upd) begin
      pend_idx_r <= row_r;
    end
    if (pv_r && scan_bad && !found_r) begin
      first_r <= pa_r;
    end
    if (cmd.scan_step) begin
      pa_r <= sweep_r;
    end
  end

  // Output register loads.
  always_ff @(posedge clk) begin
    if (cmd.upd && (oor || rowrep)) begin
      o_kind_r  <= oor ? KIND_RANGE : KIND_ROW;
      o_idx_r   <= row_r;
      o_err_r   <= err_inc;
      o_unref_r <= '0;
      o_over_r  <= '0;
      o_pass_r  <= 1'b0;
      o_last_r  <= !(oor && rowrep);
    end else if (cmd.load_row) begin
      o_kind_r  <= KIND_ROW;
      o_idx_r   <= pend_idx_r;
      o_err_r   <= err_inc;
      o_unref_r <= '0;
      o_over_r  <= '0;
      o_pass_r  <= 1'b0;
      o_last_r  <= 1'b1;
    end else if (cmd.load_sum) begin
      o_kind_r  <= KIND_SUMMARY;
      o_idx_r   <= found_r ? INDEX_W'(first_r) : '0;
      o_err_r   <= err_r;
      o_unref_r <= TALLY_W'(unref_r);
      o_over_r  <= TALLY_W'(over_r);
      o_pass_r  <= (err_r == '0);
      o_last_r  <= 1'b1;
    end
  end

  assign sts.has_result = oor || rowrep;
  assign sts.row_pend   = rowpend_r;
  assign sts.sweep_last = sweep_last;

  assign out_report_kind          = o_kind_r;
  assign out_report_index         = o_idx_r;
  assign out_error_total          = o_err_r;
  assign out_unreferenced_count   = o_unref_r;
  assign out_overreferenced_count = o_over_r;
  assign out_passed               = o_pass_r;
  assign out_last                 = o_last_r;

endmodule : mmrc_dp

`default_nettype wire

// File: hw/rtl/mesh_map_reference_checker.sv
// Entry item: the entry is registered with its count read, then updated,
// which loads any result; the next item is taken after the update when it
// causes no result, else once the last result leaves. Finish item: the scan
// reads the count memory one entry per cycle and zeroes it behind itself;
// a flush and the summary load follow. Reset: a clearing pass zeroes the
// count memory, with in_stall high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
// mesh_map_reference_checker
// Checks a streamed mesh connectivity map: range checks each entry, keeps
// saturating reference counts, in identity mode reports rows with no valid
// neighbor and emits a summary of unreferenced and overused targets on finish.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_map_reference_checker
  import mmrc_pkg::*;
#(
  parameter int MAX_SET_SIZE  = 65536,
  parameter int MAX_ROW_WIDTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_cmd,
  input  wire logic signed [31:0]   in_entry_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_report_kind,
  output logic [15:0]               out_report_index,
  output logic [31:0]               out_error_total,
  output logic [16:0]               out_unreferenced_count,
  output logic [16:0]               out_overreferenced_count,
  output logic                      out_passed,
  output logic                      out_last,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [16:0]          cfg_wdata
);

  mmrc_cmd_t cmd;
  mmrc_sts_t sts;

  // Sequencing of clearing, updates, scan and result hand-off.
  mmrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Count memory, counters and output register.
  mmrc_dp #(
    .MAX_SET_SIZE  (MAX_SET_SIZE),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .sts                      (sts),
    .in_entry_value           (in_entry_value),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata),
    .out_report_kind          (out_report_kind),
    .out_report_index         (out_report_index),
    .out_error_total          (out_error_total),
    .out_unreferenced_count   (out_unreferenced_count),
    .out_overreferenced_count (out_overreferenced_count),
    .out_passed               (out_passed),
    .out_last                 (out_last)
  );

endmodule : mesh_map_reference_checker

`default_nettype wire

// File: tb/mesh_map_reference_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_map_reference_checker_tb
// Streams map entries and finish commands into the checker and compares every
// report against a predictor that keeps its own count table, row state and
// register copies. Items go through a valid/stall driver and reports through
// a monitor, with several sender and receiver idling patterns. Register
// settings change between phases, and their extremes are included.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_map_reference_checker_tb;
  import mmrc_pkg::*;

  localparam int COUNT_DEPTH    = 65536;
  localparam int ROW_WIDTH_MAX  = 8;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTED   = 10;

  // Register index past the end of the register list; writes are dropped.
  localparam logic [CFGI_W-1:0] CFG_SPARE = 2'd3;

  // Input commands.
  localparam logic CMD_ENTRY  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] value;
  } map_item_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] index;
    logic [31:0] errs;
    logic [16:0] unref;
    logic [16:0] over;
    logic        passed;
    logic        last;
  } map_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_cmd = CMD_ENTRY;
  logic signed [31:0]  in_entry_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_report_kind;
  logic [15:0]         out_report_index;
  logic [31:0]         out_error_total;
  logic [16:0]         out_unreferenced_count;
  logic [16:0]         out_overreferenced_count;
  logic                out_passed;
  logic                out_last;
  logic                cfg_we = 1'b0;
  logic [CFGI_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  mesh_map_reference_checker #(
    .MAX_SET_SIZE (COUNT_DEPTH),
    .MAX_ROW_WIDTH(ROW_WIDTH_MAX)
  ) DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_cmd                  (in_cmd),
    .in_entry_value          (in_entry_value),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_report_kind         (out_report_kind),
    .out_report_index        (out_report_index),
    .out_error_total         (out_error_total),
    .out_unreferenced_count  (out_unreferenced_count),
    .out_overreferenced_count(out_overreferenced_count),
    .out_passed              (out_passed),
    .out_last                (out_last),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus waiting for the driver, and reports waiting for the monitor.
  map_item_t   pending_items[$];
  map_report_t expected_reports[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  // Predictor copy of the checker state and registers.
  logic [CNT_W-1:0]   hit_count [0:COUNT_DEPTH-1];
  logic [15:0]        cur_row = '0;
  int                 cur_col = 0;
  logic               row_linked = 1'b0;
  logic [31:0]        err_tally = '0;
  logic               mode_identity = IDENTITY_RST;
  logic [TSIZE_W-1:0] size_limit = TARGET_SZ_RST;
  logic [RWID_W-1:0]  width_reg = ROW_WIDTH_RST;

  // Register settings of the random phases: identity mode, target size, row width.
  int set_id[8]  = '{1, 0, 1, 0, 1, 1, 0, 1};
  int set_tsz[8] = '{5, 0, 131071, 9, 1, 12, 65536, 6};
  int set_rw[8]  = '{2, 1, 8, 15, 0, 4, 5, 3};

  initial begin
    for (int i = 0; i < COUNT_DEPTH; i++) hit_count[i] = '0;
  end

  function automatic int eff_targets(logic [TSIZE_W-1:0] sz);
    return (sz > COUNT_DEPTH) ? COUNT_DEPTH : int'(sz);
  endfunction

  function automatic int eff_width(logic [RWID_W-1:0] w);
    if (w == 0) return 1;
    return (w > ROW_WIDTH_MAX) ? ROW_WIDTH_MAX : int'(w);
  endfunction

  function automatic void bump_errors();
    if (err_tally != 32'hFFFF_FFFF) err_tally = err_tally + 1;
  endfunction

  function automatic void add_report(kind_t kind, logic [15:0] idx, logic [16:0] unref,
                                     logic [16:0] over, logic passed);
    map_report_t r;
    r.kind   = kind;
    r.index  = idx;
    r.errs   = err_tally;
    r.unref  = unref;
    r.over   = over;
    r.passed = passed;
    r.last   = 1'b0;
    expected_reports = {expected_reports, r};
  endfunction

  // Works out the reports caused by one accepted item and advances the state.
  function automatic void predict_reports(logic cmd, logic [31:0] value);
    int          targets;
    int          width;
    int          produced;
    logic [16:0] unref;
    logic [16:0] over;
    logic [15:0] first_bad;
    logic        found;
    logic        bad;
    targets  = eff_targets(size_limit);
    width    = eff_width(width_reg);
    produced = 0;
    unref    = '0;
    over     = '0;
    first_bad = '0;
    found    = 1'b0;

    if (cmd == CMD_FINISH) begin
      // Scan the count table, then return the table, row state and error tally to reset.
      for (int i = 0; i < targets; i++) begin
        bad = 1'b0;
        if (hit_count[i] == 0) begin
          unref++;
          bump_errors();
          bad = 1'b1;
        end
        if (mode_identity && hit_count[i] > width) begin
          over++;
          bump_errors();
          bad = 1'b1;
        end
        if (bad && !found) begin
          found = 1'b1;
          first_bad = i[15:0];
        end
      end
      add_report(KIND_SUMMARY, first_bad, unref, over, err_tally == 0);
      expected_reports[$].last = 1'b1;
      for (int i = 0; i < COUNT_DEPTH; i++) hit_count[i] = '0;
      cur_row    = '0;
      cur_col    = 0;
      row_linked = 1'b0;
      err_tally  = '0;
      return;
    end

    // Range check, then count the reference.
    if (value[31] || value >= targets) begin
      bump_errors();
      add_report(KIND_RANGE, cur_row, '0, '0, 1'b0);
      produced++;
    end else begin
      if (hit_count[value[15:0]] != CNT_MAX) hit_count[value[15:0]]++;
      if (value[15:0] != cur_row && value != 0) row_linked = 1'b1;
    end

    // Close the row once the column count reaches the effective width.
    cur_col++;
    if (cur_col >= width) begin
      if (mode_identity && !row_linked) begin
        bump_errors();
        add_report(KIND_ROW, cur_row, '0, '0, 1'b0);
        produced++;
      end
      cur_col    = 0;
      row_linked = 1'b0;
      cur_row    = cur_row + 1'b1;
    end
    if (produced > 0) expected_reports[$].last = 1'b1;
  endfunction

  // Driver: predicts each accepted item and presents the next one.
  always @(posedge clk) begin : item_driver
    map_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_reports(in_cmd, in_entry_value);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items[0];
          pending_items.delete(0);
          in_valid       <= 1'b1;
          in_cmd         <= nxt.cmd;
          in_entry_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: compares each accepted report with the oldest expectation.
  always @(posedge clk) begin : report_monitor
    map_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("%0t: unexpected report kind=%0d index=%0d", $realtime,
                   out_report_kind, out_report_index);
      end else begin
        want = expected_reports[0];
        expected_reports.delete(0);
        if (want.kind != out_report_kind || want.index != out_report_index ||
            want.errs != out_error_total || want.unref != out_unreferenced_count ||
            want.over != out_overreferenced_count || want.passed != out_passed ||
            want.last != out_last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED) begin
            $display("%0t: report mismatch", $realtime);
            $display("  expected kind=%0d index=%0d errors=%0d unref=%0d over=%0d pass=%0d last=%0d",
                     want.kind, want.index, want.errs, want.unref, want.over,
                     want.passed, want.last);
            $display("  actual   kind=%0d index=%0d errors=%0d unref=%0d over=%0d pass=%0d last=%0d",
                     out_report_kind, out_report_index, out_error_total,
                     out_unreferenced_count, out_overreferenced_count, out_passed, out_last);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_entry(logic [31:0] value);
    map_item_t item;
    item.cmd   = CMD_ENTRY;
    item.value = value;
    pending_items = {pending_items, item};
  endtask

  task automatic queue_finish();
    map_item_t item;
    item.cmd   = CMD_FINISH;
    item.value = $urandom;
    pending_items = {pending_items, item};
  endtask

  task automatic set_idling(int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      default: begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  // Waits until every item is taken and every report has arrived.
  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the predictor copy follows at the write edge.
  task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_IDENTITY:  mode_identity = data[0];
      CFG_TARGET_SZ: size_limit    = data[TSIZE_W-1:0];
      CFG_ROW_WIDTH: width_reg     = data[RWID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int id, int tsz, int rw);
    write_reg(CFG_IDENTITY, CFG_W'(id));
    write_reg(CFG_TARGET_SZ, CFG_W'(tsz));
    write_reg(CFG_ROW_WIDTH, CFG_W'(rw));
    cfg_we <= 1'b0;
  endtask

  // Mostly small in-range targets, some anywhere in range, some at the bound
  // and some raw 32-bit words (negative and far out of range).
  function automatic logic [31:0] pick_entry(int targets);
    int roll;
    int span;
    roll = $urandom_range(99);
    if (targets == 0 || roll < 12) return $urandom;
    if (roll < 14) return targets;
    if (roll < 16) return targets - 1;
    if (roll < 30) return $urandom_range(targets - 1);
    span = (targets < 12) ? targets : 12;
    return $urandom_range(span - 1);
  endfunction

  initial begin : stimulus
    int count;
    int targets;
    logic [31:0] v;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Register reset values: out-of-range extremes and a row with two reports.
    set_idling(0);
    queue_entry(32'd0);
    queue_entry(32'h7FFF_FFFF);
    queue_entry(32'h8000_0000);
    queue_entry(32'd65535);
    queue_entry(32'd65536);
    queue_entry(32'hFFFF_FFFF);
    queue_entry(32'd2);
    queue_entry(32'd2);
    queue_entry(32'd0);
    queue_entry(32'd7);
    queue_finish();
    wait_drained();

    // A write past the register list must change nothing; then a clean
    // identity map over four targets that passes.
    write_reg(CFG_SPARE, 17'h1FFFF);
    apply_setting(1, 4, 3);
    set_idling(3);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        if (c != r) queue_entry(c);
    queue_finish();
    wait_drained();

    // Width one: the count of target one saturates and overruns the limit,
    // and rows that name themselves or target zero are reported.
    apply_setting(1, 65536, 1);
    set_idling(0);
    for (int r = 0; r < 24; r++) begin
      if (r == 5) v = 32'd5;
      else if (r == 9) v = 32'd0;
      else v = 32'd1;
      queue_entry(v);
    end
    queue_finish();
    wait_drained();

    // Random phases, each with its own setting; a finish closes every other one,
    // so rows are often left open across a width change or dropped at finish.
    for (int p = 0; p < 8; p++) begin
      apply_setting(set_id[p], set_tsz[p], set_rw[p]);
      set_idling(p % 4);
      targets = eff_targets(TSIZE_W'(set_tsz[p]));
      count = 80 + $urandom_range(20);
      for (int k = 0; k < count; k++) queue_entry(pick_entry(targets));
      if (p % 2 == 1) queue_finish();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $display("%0d expected reports never arrived", expected_reports.size());
      mismatch_count += expected_reports.size();
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
